// ===== design/cbq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbq_pkg;

  // Number of biquad sections in the cascade.
  localparam int SECTIONS = 2;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int VAL_W    = 32;
  localparam int PROD_W   = VAL_W + COEF_W;
  localparam int IDX_W    = 4;
  localparam int SLOT_W   = 8;
  localparam int PHASE_W  = 3;

  // Operation codes carried in s_tuser.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Phase at which a section makes its last accumulation.
  localparam logic [PHASE_W-1:0] LAST_PHASE = 3'd5;

  localparam logic signed [39:0] VMAX = 40'sd2147483647;
  localparam logic signed [39:0] VMIN = -40'sd2147483648;

  typedef struct packed {
    logic                    clip;
    logic signed [VAL_W-1:0] val;
  } satv_t;

  // Value travelling from one cell to the next.
  typedef struct packed {
    logic                    vld;
    logic                    clip;
    logic signed [VAL_W-1:0] acc;
  } link_t;

  // Coefficient write broadcast to every cell.
  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] val;
  } cwr_t;

  function automatic satv_t sat32(input logic signed [39:0] x);
    satv_t r;
    r.clip = 1'b1;
    if (x > VMAX) begin
      r.val = VMAX[VAL_W-1:0];
    end else if (x < VMIN) begin
      r.val = VMIN[VAL_W-1:0];
    end else begin
      r.val  = x[VAL_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Round a Q24.8 by Q4.20 product back to Q24.8, halves upwards.
  function automatic satv_t mulq(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] r;
    r = {p[PROD_W-1], p} + 57'sd524288;
    return sat32({{3{r[PROD_W]}}, r[PROD_W:20]});
  endfunction

  function automatic satv_t add_sat(input logic signed [VAL_W-1:0] a,
                                    input logic signed [VAL_W-1:0] b,
                                    input logic                    sub);
    logic signed [39:0] ea;
    logic signed [39:0] eb;
    ea = {{8{a[VAL_W-1]}}, a};
    eb = {{8{b[VAL_W-1]}}, b};
    return sat32(sub ? (ea - eb) : (ea + eb));
  endfunction

endpackage

`default_nettype wire

// ===== design/cbq_gain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbq_gain (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [cbq_pkg::SAMPLE_W-1:0]  sample,
  input  wire cbq_pkg::cwr_t                        cwr,
  output cbq_pkg::link_t                            out
);
  import cbq_pkg::*;

  logic signed [COEF_W-1:0] gain;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  mq;
  logic                     clip;
  logic                     v1;
  logic                     v2;
  satv_t                    mr;
  logic signed [VAL_W-1:0]  scaled;

  assign scaled = {{(VAL_W-SAMPLE_W-8){sample[SAMPLE_W-1]}}, sample, 8'b0};
  assign mr     = mulq(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      if (cwr.we && cwr.idx == '0) begin
        gain <= cwr.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(scaled) * PROD_W'(gain);
    end
    if (v1) begin
      mq   <= mr.val;
      clip <= mr.clip;
    end
  end

  assign out.vld  = v2;
  assign out.clip = clip;
  assign out.acc  = mq;

endmodule

`default_nettype wire

// ===== design/cbq_section.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbq_section (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [cbq_pkg::SLOT_W-1:0]  base,
  input  wire cbq_pkg::cwr_t               cwr,
  input  wire cbq_pkg::link_t              din,
  output cbq_pkg::link_t                   dout
);
  import cbq_pkg::*;

  logic signed [COEF_W-1:0] coef [4];
  logic signed [VAL_W-1:0]  h1;
  logic signed [VAL_W-1:0]  h2;
  logic signed [VAL_W-1:0]  w;
  logic signed [VAL_W-1:0]  acc;
  logic signed [VAL_W-1:0]  mq;
  logic signed [PROD_W-1:0] prod;
  logic                     clip;
  logic                     busy;
  logic                     done;
  logic [PHASE_W-1:0]       phase;
  logic [SLOT_W:0]          diff;
  logic                     hit;
  logic signed [VAL_W-1:0]  op_h;
  logic signed [COEF_W-1:0] op_c;
  satv_t                    mr;
  satv_t                    sum;
  logic                     do_mul;
  logic                     do_rnd;
  logic                     do_acc;

  // Slots base .. base+3 belong to this section.
  assign diff = {{(SLOT_W-IDX_W+1){1'b0}}, cwr.idx} - {1'b0, base};
  assign hit  = cwr.we && (diff[SLOT_W:2] == '0);

  // Products go h1*pole1, h2*pole2, h1*zero1, h2*zero2; phase k multiplies,
  // phase k+1 rounds and phase k+2 accumulates.
  assign op_h   = phase[0] ? h2 : h1;
  assign op_c   = coef[phase[1:0]];
  assign do_mul = busy && (phase < 3'd4);
  assign do_rnd = busy && (phase >= 3'd1) && (phase <= 3'd4);
  assign do_acc = busy && (phase >= 3'd2);
  assign mr     = mulq(prod);
  assign sum    = add_sat(acc, mq, phase < 3'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
      h1    <= '0;
      h2    <= '0;
      for (int i = 0; i < 4; i++) begin
        coef[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (hit) begin
        coef[diff[1:0]] <= cwr.val;
      end
      if (din.vld) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase == LAST_PHASE) begin
          busy <= 1'b0;
          done <= 1'b1;
          h2   <= h1;
          h1   <= w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.vld) begin
      acc  <= din.acc;
      clip <= din.clip;
    end else begin
      if (do_mul) begin
        prod <= PROD_W'(op_h) * PROD_W'(op_c);
      end
      if (do_rnd) begin
        mq <= mr.val;
      end
      if (do_acc) begin
        acc <= sum.val;
      end
      if (do_acc && phase == 3'd3) begin
        w <= sum.val;
      end
      clip <= clip | (do_rnd & mr.clip) | (do_acc & sum.clip);
    end
  end

  assign dout.vld  = done;
  assign dout.clip = clip;
  assign dout.acc  = acc;

endmodule

`default_nettype wire

// ===== design/cascaded_biquad_iir_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata (low bit up)                               tuser
// s_*      in   sample_in[15:0] coef_index[19:16]                operation
//               coef_value[43:20], zero pad [47:44]              (0 filter, 1 coef write)
// m_*      out  sample_out[15:0]                                 saturated
//
// A filter word passes through the gain stage and then through each section
// cell, which has one multiplier that it uses four times in turn.
// A coefficient write gives no word.
// Reset clears the coefficients and the history at once; no clearing pass.
// The input stalls while a word is in the cascade or while a skid register
// holds a result behind a stalled output register.

module cascaded_biquad_iir_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // sample_in, coef_index, coef_value, pad
  input  wire logic        s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // sample_out
  output logic             m_tuser    // saturated
);
  import cbq_pkg::*;

  logic                       take;
  logic                       busy;
  logic                       skid_valid;
  logic [SAMPLE_W-1:0]        skid_data;
  logic                       skid_clip;
  cwr_t                       cwr;
  link_t                      chain [SECTIONS+1];
  link_t                      last;
  logic signed [VAL_W:0]      rnd;
  logic signed [24:0]         y;
  logic [SAMPLE_W-1:0]        res_data;
  logic                       res_clip;

  assign s_tready = !busy && !skid_valid;
  assign take     = s_tvalid && s_tready;

  assign cwr.we  = take && (s_tuser == OP_WRITE);
  assign cwr.idx = s_tdata[19:16];
  assign cwr.val = s_tdata[43:20];

  // The gain stage feeds the first section; each section feeds the next.
  cbq_gain u_gain (
    .clk    (clk),
    .rst    (rst),
    .start  (take && (s_tuser == OP_FILTER)),
    .sample (s_tdata[15:0]),
    .cwr    (cwr),
    .out    (chain[0])
  );

  for (genvar s = 0; s < SECTIONS; s++) begin : g_sec
    cbq_section u_sec (
      .clk  (clk),
      .rst  (rst),
      .base (SLOT_W'(1 + 4 * s)),
      .cwr  (cwr),
      .din  (chain[s]),
      .dout (chain[s+1])
    );
  end

  assign last = chain[SECTIONS];

  // Final Q24.8 value: add a half, drop the fraction, clip to 16 bits.
  assign rnd = {last.acc[VAL_W-1], last.acc} + 33'sd128;
  assign y   = rnd[VAL_W:8];

  always_comb begin
    res_clip = last.clip;
    if (y > 25'sd32767) begin
      res_data = 16'h7fff;
      res_clip = 1'b1;
    end else if (y < -25'sd32768) begin
      res_data = 16'h8000;
      res_clip = 1'b1;
    end else begin
      res_data = y[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take && (s_tuser == OP_FILTER)) begin
        busy <= 1'b1;
      end else if (last.vld) begin
        busy <= 1'b0;
      end
      if (last.vld) begin
        if (m_tvalid && !m_tready) begin
          skid_valid <= 1'b1;
        end else begin
          m_tvalid <= 1'b1;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid   <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.vld) begin
      if (m_tvalid && !m_tready) begin
        skid_data <= res_data;
        skid_clip <= res_clip;
      end else begin
        m_tdata <= res_data;
        m_tuser <= res_clip;
      end
    end else if (m_tvalid && m_tready && skid_valid) begin
      m_tdata <= skid_data;
      m_tuser <= skid_clip;
    end
  end

  // A result never arrives while the skid register is still occupied.
  a_no_skid_overrun: assert property (@(posedge clk) disable iff (rst)
    last.vld |-> !skid_valid)
    else $error("result arrived with skid register full");

  // An accepted filter word keeps the cascade busy in the next cycle.
  a_busy_on_filter: assert property (@(posedge clk) disable iff (rst)
    (take && (s_tuser == OP_FILTER)) |=> busy)
    else $error("filter word accepted but cascade not busy");

  // The cascade only goes idle as the last section hands over its result.
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(last.vld))
    else $error("cascade went idle without a result");

  // Coefficient writes are only taken while the cascade is idle.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    cwr.we |-> !busy && !last.vld)
    else $error("coefficient write while a word is in the cascade");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Bench for the cascaded biquad filter. Sample words and coefficient words are
// queued up front, a clocked driver feeds them over the slave stream with
// random gaps, and a clocked monitor takes result words with random stalls.
// Each word accepted at the input is run through a local model of the gain
// stage and the biquad cascade. That model keeps its own coefficient table
// and history. Each sample word pushes the result that it should produce, and
// the monitor compares every result word, field by field, with the oldest one.

module tb;
  import cbq_pkg::*;

  localparam int N_COEF         = 1 + 4 * SECTIONS;
  localparam int N_HIST         = 2 * SECTIONS;
  localparam int RANDOM_WORDS   = 1550;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 1000;

  // One input word as the driver sees it, before packing into tdata and tuser.
  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           idx;
    logic signed [COEF_W-1:0]   coef;
  } word_t;

  // One result word: the filtered sample and its clip flag.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } pcm_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // sample_in, coef_index, coef_value, pad
  logic        s_tuser  = 1'b0; // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // sample_out
  logic        m_tuser;         // saturated

  cascaded_biquad_iir_filter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Words still to be sent, and the results still owed by the block.
  word_t pending_words[$];
  pcm_t  expected_pcm[$];

  int words_total  = 0;
  int words_taken  = 0;
  int random_words = 0;
  int failures     = 0;
  int quiet_cycles = 0;

  // Local copy of the filter state.
  logic signed [COEF_W-1:0] coef_q [N_COEF];
  logic signed [VAL_W-1:0]  hist_q [N_HIST];
  logic                     clip_flag;

  initial begin
    foreach (coef_q[i]) coef_q[i] = '0;
    foreach (hist_q[i]) hist_q[i] = '0;
  end

  // Saturate to the 32-bit Q24.8 range, noting any clipping.
  function automatic logic signed [VAL_W-1:0] clamp32(input longint x);
    if (x > 64'sd2147483647) begin
      clip_flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      clip_flag = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Q24.8 value times Q4.20 coefficient, rounded half up back to Q24.8.
  function automatic logic signed [VAL_W-1:0] scale_q(input logic signed [VAL_W-1:0] v,
                                                      input logic signed [COEF_W-1:0] c);
    longint p;
    p = longint'(v) * longint'(c);
    return clamp32((p + 64'sd524288) >>> 20);
  endfunction

  // Runs one sample through the gain stage and every section, updating the
  // history as it goes, and returns the result word the block should give.
  function automatic pcm_t run_biquads(input logic signed [SAMPLE_W-1:0] x);
    logic signed [VAL_W-1:0] acc;
    logic signed [VAL_W-1:0] w;
    logic signed [VAL_W-1:0] h1;
    logic signed [VAL_W-1:0] h2;
    longint                  y;
    int                      base;
    pcm_t                    r;
    clip_flag = 1'b0;
    acc = scale_q({{8{x[SAMPLE_W-1]}}, x, 8'h00}, coef_q[0]);
    for (int sec = 0; sec < SECTIONS; sec++) begin
      base = 1 + 4 * sec;
      h1   = hist_q[2 * sec];
      h2   = hist_q[2 * sec + 1];
      acc  = clamp32(longint'(acc) - longint'(scale_q(h1, coef_q[base])));
      w    = clamp32(longint'(acc) - longint'(scale_q(h2, coef_q[base + 1])));
      acc  = clamp32(longint'(w) + longint'(scale_q(h1, coef_q[base + 2])));
      acc  = clamp32(longint'(acc) + longint'(scale_q(h2, coef_q[base + 3])));
      hist_q[2 * sec + 1] = h1;
      hist_q[2 * sec]     = w;
    end
    y = (longint'(acc) + 64'sd128) >>> 8;
    if (y > 32767) begin
      y = 32767;
      clip_flag = 1'b1;
    end
    if (y < -32768) begin
      y = -32768;
      clip_flag = 1'b1;
    end
    r.sample_out = y[15:0];
    r.saturated  = clip_flag;
    return r;
  endfunction

  // Applies one accepted input word to the local state.
  function automatic void apply_word(input word_t wd);
    if (wd.op == OP_WRITE) begin
      if (wd.idx < N_COEF) coef_q[wd.idx] = wd.coef;
    end else begin
      expected_pcm.push_back(run_biquads(wd.sample));
    end
  endfunction

  function automatic int rand_span(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Coefficient word; the sample field carries noise that the block must ignore.
  task automatic push_coef(input logic [IDX_W-1:0] idx, input logic signed [COEF_W-1:0] val);
    word_t wd;
    wd.op     = OP_WRITE;
    wd.sample = SAMPLE_W'($urandom());
    wd.idx    = idx;
    wd.coef   = val;
    pending_words.push_back(wd);
    words_total++;
    if (idx < N_COEF) random_words++;
  endtask

  // Sample word; the coefficient fields carry noise.
  task automatic push_pcm(input logic signed [SAMPLE_W-1:0] x);
    word_t wd;
    wd.op     = OP_FILTER;
    wd.sample = x;
    wd.idx    = IDX_W'($urandom());
    wd.coef   = COEF_W'($urandom());
    pending_words.push_back(wd);
    words_total++;
    random_words++;
  endtask

  // Loads a full coefficient set. Tame sets keep the poles small so that the
  // cascade stays stable; wild sets use the whole range and clip readily.
  task automatic load_set(input int style);
    logic signed [COEF_W-1:0] v;
    for (int i = 0; i < N_COEF; i++) begin
      if (style == 0) begin
        v = (i == 0) ? 24'sh100000 : 24'sh0;
      end else if (style == 1) begin
        if (i == 0) v = COEF_W'(rand_span(1 << 21));
        else if (((i - 1) % 4) < 2) v = COEF_W'(rand_span((1 << 19) - 1));
        else v = COEF_W'(rand_span(1 << 21));
      end else begin
        v = COEF_W'($urandom());
      end
      push_coef(IDX_W'(i), v);
    end
    if ($urandom_range(0, 3) == 0) begin
      push_coef(IDX_W'($urandom_range(N_COEF, 15)), COEF_W'($urandom()));
    end
  endtask

  // Each side alternates between stretches with no idling and stretches in
  // which every word draws a random wait.
  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;

  function automatic int draw_in_wait();
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    return in_steady ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic int draw_out_stall();
    if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
    return out_steady ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Driver: holds a word on the slave side until it is taken, then waits the
  // drawn gap before presenting the next. s_tvalid gets one assignment a step.
  word_t held_word;
  int    in_wait = 0;

  always @(posedge clk) begin
    logic want_valid;
    want_valid = s_tvalid;
    if (rst) begin
      want_valid = 1'b0;
      in_wait    = draw_in_wait();
    end else begin
      if (s_tvalid && s_tready) begin
        apply_word(held_word);
        words_taken++;
        want_valid = 1'b0;
        in_wait    = draw_in_wait();
      end
      if (!want_valid) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (pending_words.size() > 0) begin
          held_word  = pending_words.pop_front();
          s_tdata    <= {4'h0, held_word.coef, held_word.idx, held_word.sample};
          s_tuser    <= held_word.op;
          want_valid = 1'b1;
        end
      end
    end
    s_tvalid <= want_valid;
  end

  // Monitor: takes result words, checks them against the oldest expectation
  // and stalls the master side for a drawn number of cycles after each one.
  int out_stall = 0;

  always @(posedge clk) begin
    pcm_t want;
    logic next_ready;
    next_ready = 1'b0;
    if (rst) begin
      out_stall = draw_out_stall();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pcm.size() == 0) begin
          $error("result word with nothing expected: sample_out %0d saturated %0b",
                 $signed(m_tdata), m_tuser);
          failures++;
        end else begin
          want = expected_pcm.pop_front();
          if (m_tdata !== want.sample_out) begin
            $error("sample_out expected %0d actual %0d", want.sample_out, $signed(m_tdata));
            failures++;
          end
          if (m_tuser !== want.saturated) begin
            $error("saturated expected %0b actual %0b", want.saturated, m_tuser);
            failures++;
          end
        end
        out_stall = draw_out_stall();
      end
      if (out_stall > 0) out_stall--;
      else next_ready = 1'b1;
    end
    m_tready <= next_ready;
  end

  // Watchdog: a long spell with no word moving on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int style;
    int n;

    // Nothing loaded yet: a gain of zero silences even a full-scale sample.
    push_pcm(16'sh7fff);
    // Unity gain with empty sections passes the extremes straight through.
    push_coef(4'd0, 24'sh100000);
    push_pcm(16'sh8000);
    push_pcm(16'sh7fff);
    push_pcm(16'sd1);
    push_pcm(-16'sd1);
    // Largest and most negative gains clip the output.
    push_coef(4'd0, 24'sh7fffff);
    push_pcm(16'sh7fff);
    push_pcm(16'sh8000);
    push_coef(4'd0, 24'sh800000);
    push_pcm(16'sh8000);
    // Writes past the end of the table must leave it alone.
    push_coef(4'd9, 24'sh7fffff);
    push_coef(4'd15, 24'sh800000);
    push_pcm(16'sd1000);
    // Extreme section coefficients drive products and sums into clipping.
    push_coef(4'd0, 24'sh100000);
    push_coef(4'd1, 24'sh7fffff);
    push_coef(4'd2, 24'sh800000);
    push_coef(4'd3, 24'sh7fffff);
    push_coef(4'd4, 24'sh800000);
    push_coef(4'd5, 24'sh800000);
    push_coef(4'd6, 24'sh7fffff);
    push_coef(4'd7, 24'sh800000);
    push_coef(4'd8, 24'sh7fffff);
    push_pcm(16'sh7fff);
    push_pcm(16'sh8000);
    push_pcm(16'sd0);

    // Random part: mostly a coefficient set followed by a run of samples,
    // with the odd stray coefficient word landing in the middle of a run.
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      n = $urandom_range(0, 9);
      style = (n < 1) ? 0 : ((n < 8) ? 1 : 2);
      load_set(style);
      n = $urandom_range(20, 80);
      repeat (n) begin
        if ($urandom_range(0, 24) == 0) begin
          push_coef(IDX_W'($urandom_range(0, 15)), COEF_W'($urandom()));
        end
        if ($urandom_range(0, 1) == 0) push_pcm(SAMPLE_W'($urandom()));
        else push_pcm(SAMPLE_W'(rand_span(4000)));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (words_taken != words_total) @(negedge clk);
    while (expected_pcm.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cbq_pkg.sv
design/cbq_gain.sv
design/cbq_section.sv
design/cascaded_biquad_iir_filter.sv
bench/tb.sv
